>>> hdl/rws_pkg.sv
package rws_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SKIP_W   = 7;
  localparam int SUM_W    = ((CNT_W > SKIP_W + 1) ? CNT_W : SKIP_W + 1) + 1;

  localparam logic REG_SKIP_HIGH = 1'b0;
  localparam logic REG_SKIP_LOW  = 1'b1;

  typedef struct packed {
    logic signed [31:0] record_id;
    logic signed [31:0] record_rating;
    logic               set_end;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_id;
    logic signed [31:0] out_rating;
    logic               run_last;
    logic               overflowed;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] id;
    logic signed [31:0] rating;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shl;
    logic clr;
  } chain_ctl_t;

endpackage

>>> hdl/ranked_window_sorter.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_data   (rws_pkg::in_t)
// out     | output    | out_valid/out_stall| out_data  (rws_pkg::out_t)
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Loading: one record per cycle, each inserted in rank order into the cell chain
// while it has room. After set_end, if a window remains, the chain shifts toward
// its head once per cycle in which the output register is free, past skip_high
// records and the window; then the next set may load. in_stall is high for the
// whole drain. Reset empties the chain at once and zeroes both skip registers.
module ranked_window_sorter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rws_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rws_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [rws_pkg::SKIP_W-1:0]   cfg_data
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                        state, state_next;
  logic [rws_pkg::SKIP_W-1:0]  skip_high, skip_low;
  logic [rws_pkg::CNT_W-1:0]   count, count_next;
  logic                        drop, drop_next;
  logic [rws_pkg::CNT_W-1:0]   idx, idx_next;
  logic [rws_pkg::CNT_W-1:0]   stop, stop_next;
  logic                        set_ovf, set_ovf_next;
  logic                        out_valid_next;
  logic                        emit;
  logic                        accept;
  logic                        room;
  logic [rws_pkg::SUM_W-1:0]   total, skip_sum;
  rws_pkg::chain_ctl_t         ctl;
  rws_pkg::entry_t             new_entry;
  rws_pkg::entry_t             head;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign room     = (count != rws_pkg::CNT_W'(rws_pkg::CAPACITY));
  assign total    = rws_pkg::SUM_W'(count) + rws_pkg::SUM_W'(room);
  assign skip_sum = rws_pkg::SUM_W'(skip_high) + rws_pkg::SUM_W'(skip_low);

  assign new_entry.valid  = 1'b1;
  assign new_entry.id     = in_data.record_id;
  assign new_entry.rating = in_data.record_rating;

  rws_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .new_entry (new_entry),
    .head      (head)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    drop_next      = drop;
    idx_next       = idx;
    stop_next      = stop;
    set_ovf_next   = set_ovf;
    out_valid_next = out_valid && out_stall;
    emit           = 1'b0;
    ctl            = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ctl.ins = room;
          if (in_data.set_end) begin
            count_next = '0;
            drop_next  = 1'b0;
            if (skip_sum >= total) begin
              ctl.clr = 1'b1;
            end else begin
              state_next   = ST_DRAIN;
              idx_next     = '0;
              stop_next    = rws_pkg::CNT_W'(total - rws_pkg::SUM_W'(skip_low));
              set_ovf_next = drop || !room;
            end
          end else begin
            count_next = rws_pkg::CNT_W'(total);
            drop_next  = drop || !room;
          end
        end
      end
      ST_DRAIN: begin
        if (!out_valid || !out_stall) begin
          ctl.shl  = 1'b1;
          idx_next = idx + 1'b1;
          if (rws_pkg::SUM_W'(idx) >= rws_pkg::SUM_W'(skip_high)) begin
            emit           = 1'b1;
            out_valid_next = 1'b1;
          end
          if (idx_next == stop) begin
            ctl.clr    = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      drop      <= 1'b0;
      out_valid <= 1'b0;
      skip_high <= '0;
      skip_low  <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      drop      <= drop_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        unique case (cfg_index)
          rws_pkg::REG_SKIP_HIGH: skip_high <= cfg_data;
          rws_pkg::REG_SKIP_LOW:  skip_low  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    stop    <= stop_next;
    set_ovf <= set_ovf_next;
    if (emit) begin
      out_data.out_id     <= head.id;
      out_data.out_rating <= head.rating;
      out_data.run_last   <= (idx_next == stop);
      out_data.overflowed <= set_ovf;
    end
  end

endmodule

>>> hdl/rws_cell.sv
module rws_cell (
  input  logic               clk,
  input  logic               rst,
  input  rws_pkg::chain_ctl_t ctl,
  input  rws_pkg::entry_t    new_entry,
  input  rws_pkg::entry_t    left_entry,
  input  logic               left_take,
  input  rws_pkg::entry_t    right_entry,
  output rws_pkg::entry_t    entry,
  output logic               take
);

  rws_pkg::entry_t entry_next;

  // New record lands behind equal ratings to keep arrival order.
  assign take = !entry.valid || ($signed(entry.rating) < $signed(new_entry.rating));

  always_comb begin
    entry_next = entry;
    if (ctl.clr) begin
      entry_next.valid = 1'b0;
    end else if (ctl.shl) begin
      entry_next = right_entry;
    end else if (ctl.ins && take) begin
      if (left_take) begin
        entry_next = left_entry;
      end else begin
        entry_next       = new_entry;
        entry_next.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry.id     <= entry_next.id;
    entry.rating <= entry_next.rating;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

>>> hdl/rws_chain.sv
module rws_chain (
  input  logic                clk,
  input  logic                rst,
  input  rws_pkg::chain_ctl_t ctl,
  input  rws_pkg::entry_t     new_entry,
  output rws_pkg::entry_t     head
);

  rws_pkg::entry_t cells [rws_pkg::CAPACITY];
  logic            takes [rws_pkg::CAPACITY];

  for (genvar i = 0; i < rws_pkg::CAPACITY; i++) begin : g_cell
    rws_pkg::entry_t left_e;
    rws_pkg::entry_t right_e;
    logic            left_t;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_t = 1'b0;
    end else begin : g_mid
      assign left_e = cells[i-1];
      assign left_t = takes[i-1];
    end

    if (i == rws_pkg::CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cells[i+1];
    end

    rws_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_take   (left_t),
      .right_entry (right_e),
      .entry       (cells[i]),
      .take        (takes[i])
    );
  end

  assign head = cells[0];

endmodule

>>> bench/tb.sv
module tb;

  localparam int DRAIN_CYCLES = 300;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 30;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic signed [31:0] id;
    logic signed [31:0] rating;
  } ranked_rec_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  rws_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  rws_pkg::out_t out_data;
  logic          cfg_we    = 1'b0;
  logic          cfg_index = rws_pkg::REG_SKIP_HIGH;
  logic [6:0]    cfg_data  = '0;
  logic          hold_go   = 1'b0;
  int            hold_left = 0;

  rws_pkg::in_t  pending_records[$];
  rws_pkg::out_t expected_ranked[$];
  ranked_rec_t   ranked_set[$];
  logic          set_overflow    = 1'b0;
  logic [6:0]    model_skip_high = '0;
  logic [6:0]    model_skip_low  = '0;
  int            send_idle = 31;
  int            recv_idle = 70;
  int            fail_count = 0;

  ranked_window_sorter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // stable insert keeps arrival order among equal ratings
  function automatic void load_record(rws_pkg::in_t rec);
    ranked_rec_t   entry;
    rws_pkg::out_t res;
    int            pos;
    int            stop;
    int            i;
    entry.id     = rec.record_id;
    entry.rating = rec.record_rating;
    if (ranked_set.size() < rws_pkg::CAPACITY) begin
      pos = ranked_set.size();
      while (pos > 0 && ranked_set[pos-1].rating < entry.rating) pos--;
      ranked_set.insert(pos, entry);
    end else begin
      set_overflow = 1'b1;
    end
    if (rec.set_end) begin
      if (int'(model_skip_high) + int'(model_skip_low) < ranked_set.size()) begin
        stop = ranked_set.size() - int'(model_skip_low);
        for (i = int'(model_skip_high); i < stop; i++) begin
          res.out_id     = ranked_set[i].id;
          res.out_rating = ranked_set[i].rating;
          res.run_last   = (i == stop - 1);
          res.overflowed = set_overflow;
          expected_ranked.push_back(res);
        end
      end
      ranked_set.delete();
      set_overflow = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) load_record(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_records.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_data  <= pending_records.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin : result_check
    rws_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_ranked.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer id=%h rating=%h",
                                  out_data.out_id, out_data.out_rating));
      end else begin
        want = expected_ranked.pop_front();
        if (out_data.out_id !== want.out_id)
          report_mismatch($sformatf("out_id got %h exp %h", out_data.out_id, want.out_id));
        if (out_data.out_rating !== want.out_rating)
          report_mismatch($sformatf("out_rating got %h exp %h",
                                    out_data.out_rating, want.out_rating));
        if (out_data.run_last !== want.run_last)
          report_mismatch($sformatf("run_last got %b exp %b",
                                    out_data.run_last, want.run_last));
        if (out_data.overflowed !== want.overflowed)
          report_mismatch($sformatf("overflowed got %b exp %b",
                                    out_data.overflowed, want.overflowed));
      end
    end
  end

  task automatic wait_idle();
    while (pending_records.size() != 0 || in_valid || expected_ranked.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [6:0] hi, input logic [6:0] lo);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= rws_pkg::REG_SKIP_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= rws_pkg::REG_SKIP_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_skip_high = hi;
    model_skip_low  = lo;
  endtask

  task automatic push_record(input logic [31:0] id, input logic [31:0] rating,
                             input logic last);
    rws_pkg::in_t rec;
    rec.record_id     = id;
    rec.record_rating = rating;
    rec.set_end       = last;
    pending_records.push_back(rec);
  endtask

  function automatic logic [31:0] pick_rating();
    logic [31:0] r;
    case ($urandom_range(3))
      0: r = 32'($urandom_range(6)) - 32'd3;
      1: begin
        case ($urandom_range(3))
          0: r = 32'h8000_0000;
          1: r = 32'h7FFF_FFFF;
          2: r = 32'h0000_0000;
          default: r = 32'hFFFF_FFFF;
        endcase
      end
      default: r = $urandom();
    endcase
    return r;
  endfunction

  task automatic push_random_set(input int n);
    int k;
    for (k = 0; k < n; k++) push_record($urandom(), pick_rating(), k == n - 1);
  endtask

  function automatic int pick_set_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 93) return $urandom_range(40, 9);
    return $urandom_range(70, 60);
  endfunction

  initial begin : stimulus
    int ph;
    int n;
    int pushed;
    int waited;
    logic [6:0] hi;
    logic [6:0] lo;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    configure(7'd0, 7'd0);
    push_record(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    push_record(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_record(32'h0000_0000, 32'h0000_0000, 1'b0);
    push_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_record(32'h0000_0005, 32'h0000_0007, 1'b0);
    push_record(32'h0000_0006, 32'h0000_0007, 1'b0);
    push_record(32'h0000_0007, 32'h7FFF_FFFF, 1'b0);
    push_record(32'h0000_0008, 32'h8000_0000, 1'b1);
    configure(7'd2, 7'd1);
    push_record(32'h0000_0011, 32'h0000_0004, 1'b0);
    push_record(32'h0000_0012, 32'h0000_0001, 1'b0);
    push_record(32'h0000_0013, 32'h0000_0003, 1'b0);
    push_record(32'h0000_0014, 32'h0000_0002, 1'b1);
    configure(7'd2, 7'd2);
    push_random_set(4);
    configure(7'd127, 7'd0);
    push_random_set(1);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin hi = 7'd0;   lo = 7'd0;   end
        1: begin hi = 7'd1;   lo = 7'd0;   end
        2: begin hi = 7'd2;   lo = 7'd3;   end
        3: begin hi = 7'd0;   lo = 7'd1;   end
        4: begin hi = 7'd63;  lo = 7'd0;   end
        5: begin hi = 7'd0;   lo = 7'd63;  end
        6: begin hi = 7'd64;  lo = 7'd64;  end
        7: begin hi = 7'd127; lo = 7'd127; end
        default: begin
          hi = 7'($urandom_range(5));
          lo = 7'($urandom_range(5));
        end
      endcase
      configure(hi, lo);
      if (ph < 3) begin
        send_idle = 31;
        recv_idle = 70;
      end else if (ph < 6) begin
        send_idle = 70;
        recv_idle = 31;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      pushed = 0;
      case (ph)
        0: begin push_random_set(66); pushed = 66; end
        1: begin
          push_random_set(30);
          push_random_set(12);
          pushed = 42;
          @(posedge clk);
          hold_go <= 1'b1;
          @(posedge clk);
          hold_go <= 1'b0;
        end
        4: begin push_random_set(64); pushed = 64; end
        5: begin push_random_set(65); pushed = 65; end
        default: ;
      endcase
      while (pushed < PHASE_ITEMS) begin
        n = pick_set_size();
        push_random_set(n);
        pushed += n;
      end
    end

    while (pending_records.size() != 0 || in_valid) @(posedge clk);
    waited = 0;
    while (expected_ranked.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_ranked.size() != 0)
      report_mismatch($sformatf("%0d expected transfers never arrived",
                                expected_ranked.size()));

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #12000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
